// ----- src/mdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// mdsa_pkg
// Shared codes and types of the max-distance slot allocator.
// ----------------------------------------------------------------------------
package mdsa_pkg;

    // request kinds carried on s_tuser
    localparam logic KIND_CLAIM   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // configuration register map (byte addresses)
    localparam logic [2:0] ADDR_SEAT_COUNT = 3'd0;
    localparam logic [6:0] SEAT_COUNT_RST  = 7'd64;

    // per-slot control from the sequencer to one cell
    typedef struct packed {
        logic active;   // slot lies below the effective seat count
        logic set;      // mark the slot occupied
        logic clr;      // mark the slot free
    } cell_ctrl_t;

endpackage

// ----- src/mdsa_cell.sv -----
// ----------------------------------------------------------------------------
// mdsa_cell
// One slot of the row: occupancy bit, gap to the nearest occupied slot on each
// side, and one stage of the right-to-left best-slot chain.
// ----------------------------------------------------------------------------
module mdsa_cell
    import mdsa_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int INDEX = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cell_ctrl_t                   ctrl,
    input  logic                         left_occ_i,
    input  logic [$clog2(SLOTS):0]       left_gap_i,
    input  logic                         right_occ_i,
    input  logic [$clog2(SLOTS):0]       right_gap_i,
    input  logic                         best_found_i,
    input  logic [$clog2(SLOTS):0]       best_dist_i,
    input  logic [$clog2(SLOTS)-1:0]     best_idx_i,
    output logic                         occ_o,
    output logic [$clog2(SLOTS):0]       left_gap_o,
    output logic [$clog2(SLOTS):0]       right_gap_o,
    output logic                         best_found_o,
    output logic [$clog2(SLOTS):0]       best_dist_o,
    output logic [$clog2(SLOTS)-1:0]     best_idx_o
);

    localparam int IW = $clog2(SLOTS);
    localparam int GW = IW + 1;
    localparam logic [GW-1:0] GAP_INF = '1;
    localparam logic [GW-1:0] GAP_ONE = GW'(1);
    localparam logic [IW-1:0] MY_IDX  = IW'(INDEX);

    logic          occ_reg,   occ_next;
    logic [GW-1:0] lgap_reg,  lgap_next;
    logic [GW-1:0] rgap_reg,  rgap_next;
    logic          bfound_reg, bfound_next;
    logic [GW-1:0] bdist_reg, bdist_next;
    logic [IW-1:0] bidx_reg,  bidx_next;
    logic [GW-1:0] near_gap;
    logic          take;

    always_comb begin
        occ_next = occ_reg;
        if (ctrl.clr) begin
            occ_next = 1'b0;
        end else if (ctrl.set) begin
            occ_next = 1'b1;
        end

        // gap waves: saturate at infinity when no occupied slot lies that way
        if (!ctrl.active) begin
            lgap_next = GAP_INF;
        end else if (left_occ_i) begin
            lgap_next = GAP_ONE;
        end else if (left_gap_i == GAP_INF) begin
            lgap_next = GAP_INF;
        end else begin
            lgap_next = left_gap_i + GAP_ONE;
        end

        if (!ctrl.active) begin
            rgap_next = GAP_INF;
        end else if (right_occ_i) begin
            rgap_next = GAP_ONE;
        end else if (right_gap_i == GAP_INF) begin
            rgap_next = GAP_INF;
        end else begin
            rgap_next = right_gap_i + GAP_ONE;
        end

        near_gap = (lgap_reg < rgap_reg) ? lgap_reg : rgap_reg;
        // lower index wins ties, so take on equal distance
        take = ctrl.active && !occ_reg && (!best_found_i || near_gap >= best_dist_i);

        if (take) begin
            bfound_next = 1'b1;
            bdist_next  = near_gap;
            bidx_next   = MY_IDX;
        end else begin
            bfound_next = best_found_i;
            bdist_next  = best_dist_i;
            bidx_next   = best_idx_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        lgap_reg   <= lgap_next;
        rgap_reg   <= rgap_next;
        bfound_reg <= bfound_next;
        bdist_reg  <= bdist_next;
        bidx_reg   <= bidx_next;
    end

    assign occ_o        = occ_reg && ctrl.active;
    assign left_gap_o   = lgap_reg;
    assign right_gap_o  = rgap_reg;
    assign best_found_o = bfound_reg;
    assign best_dist_o  = bdist_reg;
    assign best_idx_o   = bidx_reg;

endmodule

// ----- src/max_distance_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// max_distance_slot_allocator_top
// Occupancy map of a row of slots; a claim takes the free slot farthest from
// any occupied one, a release frees a slot.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------
//   s_       | in  | tdata: position[5:0]; tuser: kind
//   m_       | out | tdata: chosen_slot[5:0]; tuser: room_full
//   apb      | in  | reg 0 at 0x0: seat_count[6:0]
//
// A release clears the registered occupancy bit of its slot. During a claim, the gap waves
// and the best-slot chain travel one cell per cycle across the row of cells.
// Reset frees every slot and sets seat_count to 64.
// A stalled result is held in the output register; the next word is taken
// meanwhile, and a finished claim waits for that register to empty.
// ----------------------------------------------------------------------------
module max_distance_slot_allocator_top
    import mdsa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] position, [7:6] zero
    input  logic        s_tuser,   // [0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] chosen_slot, [7:6] zero
    output logic        m_tuser,   // [0] room_full
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW       = $clog2(SLOTS);
    localparam int GW       = IW + 1;
    localparam int CW       = (IW + 1 > 7) ? IW + 1 : 7;
    localparam int PW       = (IW > 6) ? IW : 6;
    localparam int SCAN_LEN = 2 * SLOTS;
    localparam int TW       = $clog2(SCAN_LEN + 1);
    localparam logic [GW-1:0] GAP_INF = '1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t          state_reg;
    logic [TW-1:0]   cnt_reg;
    logic [6:0]      seat_reg;
    logic            mvalid_reg;
    logic [5:0]      mslot_reg;
    logic            mfull_reg;

    logic            in_go;
    logic            rel_go;
    logic            claim_go;
    logic            commit;
    logic [CW-1:0]   n_eff;
    logic [CW-1:0]   seat_ext;
    logic [PW-1:0]   pos_ext;
    logic [IW+5:0]   best_ext;

    logic            occ_w   [SLOTS];
    logic [GW-1:0]   lgap_w  [SLOTS];
    logic [GW-1:0]   rgap_w  [SLOTS];
    logic            bfound_w[SLOTS];
    logic [GW-1:0]   bdist_w [SLOTS];
    logic [IW-1:0]   bidx_w  [SLOTS];
    cell_ctrl_t      ctrl_w  [SLOTS];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SEAT_COUNT) ? {25'd0, seat_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seat_reg <= SEAT_COUNT_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_SEAT_COUNT) begin
            seat_reg <= pwdata[6:0];
        end
    end

    // clamp seat count into 1..SLOTS
    assign seat_ext = CW'(seat_reg);
    always_comb begin
        if (seat_ext == '0) begin
            n_eff = CW'(1);
        end else if (seat_ext > CW'(SLOTS)) begin
            n_eff = CW'(SLOTS);
        end else begin
            n_eff = seat_ext;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_go    = s_tvalid && s_tready;
    assign rel_go   = in_go && (s_tuser == KIND_RELEASE);
    assign claim_go = in_go && (s_tuser == KIND_CLAIM);
    assign commit   = (state_reg == ST_SCAN) && (cnt_reg == TW'(SCAN_LEN))
                      && (!mvalid_reg || m_tready);
    assign pos_ext  = PW'(s_tdata[5:0]);
    assign best_ext = {6'd0, bidx_w[0]};

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            logic          l_occ, r_occ;
            logic [GW-1:0] l_gap, r_gap, b_dist;
            logic          b_found;
            logic [IW-1:0] b_idx;

            if (gi == 0) begin : g_lend
                assign l_occ = 1'b0;
                assign l_gap = GAP_INF;
            end else begin : g_lmid
                assign l_occ = occ_w[gi-1];
                assign l_gap = lgap_w[gi-1];
            end

            if (gi == SLOTS - 1) begin : g_rend
                assign r_occ   = 1'b0;
                assign r_gap   = GAP_INF;
                assign b_found = 1'b0;
                assign b_dist  = '0;
                assign b_idx   = '0;
            end else begin : g_rmid
                assign r_occ   = occ_w[gi+1];
                assign r_gap   = rgap_w[gi+1];
                assign b_found = bfound_w[gi+1];
                assign b_dist  = bdist_w[gi+1];
                assign b_idx   = bidx_w[gi+1];
            end

            assign ctrl_w[gi].active = CW'(gi) < n_eff;
            assign ctrl_w[gi].set    = commit && bfound_w[0] && (bidx_w[0] == IW'(gi));
            assign ctrl_w[gi].clr    = rel_go && (pos_ext == PW'(gi));

            mdsa_cell #(
                .SLOTS (SLOTS),
                .INDEX (gi)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl_w[gi]),
                .left_occ_i   (l_occ),
                .left_gap_i   (l_gap),
                .right_occ_i  (r_occ),
                .right_gap_i  (r_gap),
                .best_found_i (b_found),
                .best_dist_i  (b_dist),
                .best_idx_i   (b_idx),
                .occ_o        (occ_w[gi]),
                .left_gap_o   (lgap_w[gi]),
                .right_gap_o  (rgap_w[gi]),
                .best_found_o (bfound_w[gi]),
                .best_dist_o  (bdist_w[gi]),
                .best_idx_o   (bidx_w[gi])
            );
        end
    endgenerate

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (commit) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (claim_go) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // hold at the end count until the output register is free
                    if (cnt_reg != TW'(SCAN_LEN)) begin
                        cnt_reg <= cnt_reg + TW'(1);
                    end
                    if (commit) begin
                        mslot_reg  <= bfound_w[0] ? best_ext[5:0] : 6'd0;
                        mfull_reg  <= !bfound_w[0];
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, mslot_reg};
    assign m_tuser  = mfull_reg;

endmodule

// ----- src/mdsa_checker.sv -----
// ----------------------------------------------------------------------------
// mdsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mdsa_checker
    import mdsa_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // a full room reports slot zero
    a_full_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 8'd0)
        else $error("room_full result with nonzero slot");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // an accepted claim closes the input while the row is scanned
    a_claim_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_CLAIM |=> !s_tready)
        else $error("input open during claim scan");

    // a result word only follows a scan
    a_result_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a claim scan");

endmodule

bind max_distance_slot_allocator_top mdsa_checker u_mdsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
